// File: design/header_compression_feedback_builder_defines.svh
// Assertion macros for the header-compression feedback builder.
// Included by the top level; depends on nothing else.
`ifndef HEADER_COMPRESSION_FEEDBACK_BUILDER_DEFINES_SVH
`define HEADER_COMPRESSION_FEEDBACK_BUILDER_DEFINES_SVH

// Check that a condition implies a consequence in the same cycle.
`define HCFB_ASSERT_SAME(label, clk, rst_n, cond, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (cons)) \
        else $error(msg);

// Check that a condition implies a consequence in the next cycle.
`define HCFB_ASSERT_NEXT(label, clk, rst_n, cond, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (cons)) \
        else $error(msg);

`endif

// File: design/hcfb_pkg.sv
// Shared types, constants and the byte-wise CRC-8 for the feedback builder.
// No dependencies.
package hcfb_pkg;

    localparam int TDATA_W = 56;
    localparam int IDX_W   = 4;

    localparam logic [7:0] SN_OPT_HDR      = 8'h41;
    localparam logic [7:0] CRC_OPT_HDR     = 8'h11;
    localparam logic [7:0] CRC8_INIT       = 8'hFF;
    localparam logic [7:0] CRC8_POLY_REFL  = 8'hE0;
    localparam logic [3:0] SMALL_CID_HDR   = 4'hE;
    localparam logic [1:0] LARGE_CID_HDR   = 2'b10;

    // One feedback request
    typedef struct packed {
        logic        mode;
        logic [1:0]  ack_type;
        logic [1:0]  operating_mode;
        logic [31:0] sequence_number;
        logic [13:0] context_id;
        logic        add_crc;
    } hcfb_req_t;

    // One byte of the packet as chosen by the layout logic
    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } hcfb_byte_t;

    // Emitter status toward the input buffer and the top level
    typedef struct packed {
        logic busy;
        logic take;
        logic step_last;
    } hcfb_emit_stat_t;

    // Fold one byte into the reflected CRC-8 (poly 0x07, LSB first)
    function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] data);
        logic [7:0] c;
        c = crc ^ data;
        for (int b = 0; b < 8; b++)
        begin
            if (c[0])
            begin
                c = (c >> 1) ^ CRC8_POLY_REFL;
            end
            else
            begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

endpackage

// File: design/hcfb_req_buf.sv
// Input register for feedback requests, one entry deep.
// Depends on hcfb_pkg.
module hcfb_req_buf (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  hcfb_pkg::hcfb_req_t in_req,
    input  logic              take,
    output logic              held_valid,
    output hcfb_pkg::hcfb_req_t held_req
);

    logic                valid_reg;
    logic                valid_next;
    hcfb_pkg::hcfb_req_t req_reg;

    // Accept when empty or when the held request leaves this cycle
    assign in_ready = !valid_reg || take;

    always_comb
    begin
        valid_next = valid_reg;
        if (in_valid && in_ready)
        begin
            valid_next = 1'b1;
        end
        else if (take)
        begin
            valid_next = 1'b0;
        end
    end

    // Clear the flag under reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Capture payload on each transfer
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            req_reg <= in_req;
        end
    end

    assign held_valid = valid_reg;
    assign held_req   = req_reg;

endmodule

// File: design/hcfb_layout.sv
// Packet layout: picks the byte at a given position of the feedback packet.
// Depends on hcfb_pkg (request type, option codes, CRC-8 step).
module hcfb_layout (
    input  hcfb_pkg::hcfb_req_t        req,
    input  logic                       large_cid,
    input  logic [hcfb_pkg::IDX_W-1:0] idx,
    input  logic [7:0]                 crc,
    output hcfb_pkg::hcfb_byte_t       out_byte
);

    logic [1:0]                 pre_len;
    logic [1:0]                 opts;
    logic                       crc_on;
    logic                       cid_long;
    logic [hcfb_pkg::IDX_W-1:0] pkt_len;
    logic [hcfb_pkg::IDX_W-1:0] body_idx;
    logic [hcfb_pkg::IDX_W-1:0] opt_end;
    logic [7:0]                 pre_byte;
    logic [7:0]                 body_byte;
    logic [7:0]                 head_byte;
    logic [3:0]                 head_nib;
    logic [1:0]                 opt_sel;

    // Select SN byte number sel (0 = lowest)
    function automatic logic [7:0] sn_byte(input logic [31:0] sn, input logic [1:0] sel);
        logic [7:0] r;
        case (sel)
            2'd0:    r = sn[7:0];
            2'd1:    r = sn[15:8];
            2'd2:    r = sn[23:16];
            default: r = sn[31:24];
        endcase
        return r;
    endfunction

    // Sizes of the prefix, the SN options and the whole packet
    always_comb
    begin
        cid_long = |req.context_id[13:7];
        if (large_cid)
        begin
            pre_len = cid_long ? 2'd2 : 2'd1;
        end
        else
        begin
            pre_len = (req.context_id != 14'd0) ? 2'd1 : 2'd0;
        end

        if (req.sequence_number[31:12] == 20'd0)
        begin
            opts = 2'd0;
        end
        else if (req.sequence_number[31:20] == 12'd0)
        begin
            opts = 2'd1;
        end
        else if (req.sequence_number[31:28] == 4'd0)
        begin
            opts = 2'd2;
        end
        else
        begin
            opts = 2'd3;
        end

        crc_on  = req.add_crc & req.mode;
        opt_end = 4'd2 + {1'b0, opts, 1'b0};
        if (req.mode)
        begin
            pkt_len = {2'b00, pre_len} + opt_end + {2'b00, crc_on, 1'b0};
        end
        else
        begin
            pkt_len = {2'b00, pre_len} + 4'd1;
        end
        body_idx = idx - {2'b00, pre_len};
    end

    // Context-id prefix byte
    always_comb
    begin
        if (large_cid)
        begin
            if (!cid_long)
            begin
                pre_byte = {1'b0, req.context_id[6:0]};
            end
            else if (idx == 4'd0)
            begin
                pre_byte = {hcfb_pkg::LARGE_CID_HDR, req.context_id[13:8]};
            end
            else
            begin
                pre_byte = req.context_id[7:0];
            end
        end
        else
        begin
            pre_byte = {hcfb_pkg::SMALL_CID_HDR, req.context_id[3:0]};
        end
    end

    // Feedback body byte
    always_comb
    begin
        head_nib  = (opts == 2'd3) ? 4'd0
                                   : 4'(sn_byte(req.sequence_number, opts + 2'd1));
        head_byte = {req.ack_type, req.operating_mode, head_nib};
        opt_sel   = opts - body_idx[2:1];
        if (!req.mode)
        begin
            body_byte = req.sequence_number[7:0];
        end
        else if (body_idx == 4'd0)
        begin
            body_byte = head_byte;
        end
        else if (body_idx == 4'd1)
        begin
            body_byte = sn_byte(req.sequence_number, opts);
        end
        else if (body_idx < opt_end)
        begin
            body_byte = body_idx[0] ? sn_byte(req.sequence_number, opt_sel)
                                    : hcfb_pkg::SN_OPT_HDR;
        end
        else if (body_idx == opt_end)
        begin
            body_byte = hcfb_pkg::CRC_OPT_HDR;
        end
        else
        begin
            // CRC data byte: checksum with the slot itself taken as zero
            body_byte = hcfb_pkg::crc8_byte(crc, 8'h00);
        end
    end

    assign out_byte.data = (idx < {2'b00, pre_len}) ? pre_byte : body_byte;
    assign out_byte.last = (idx == pkt_len - 4'd1);

endmodule

// File: design/hcfb_emit.sv
// Byte sequencer: walks the packet, runs the CRC and drives the output register.
// Depends on hcfb_pkg and hcfb_layout.
module hcfb_emit (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        large_cid,
    input  logic                        req_valid,
    input  hcfb_pkg::hcfb_req_t         req_in,
    output hcfb_pkg::hcfb_emit_stat_t   stat,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic [7:0]                  out_data,
    output logic                        out_last
);

    logic                       busy_reg;
    logic                       busy_next;
    logic [hcfb_pkg::IDX_W-1:0] idx_reg;
    logic [7:0]                 crc_reg;
    logic                       valid_reg;
    logic                       valid_next;
    logic [7:0]                 data_reg;
    logic                       last_reg;
    hcfb_pkg::hcfb_req_t        req_reg;
    hcfb_pkg::hcfb_byte_t       cur;
    logic                       out_free;
    logic                       step;
    logic                       take;

    hcfb_layout u_layout (
        .req       (req_reg),
        .large_cid (large_cid),
        .idx       (idx_reg),
        .crc       (crc_reg),
        .out_byte  (cur)
    );

    // Advance one byte when the output register can take it
    assign out_free = !valid_reg || out_ready;
    assign step     = busy_reg && out_free;
    assign take     = req_valid && (!busy_reg || (step && cur.last));

    always_comb
    begin
        busy_next = busy_reg;
        if (take)
        begin
            busy_next = 1'b1;
        end
        else if (step && cur.last)
        begin
            busy_next = 1'b0;
        end

        valid_next = valid_reg;
        if (step)
        begin
            valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            valid_next = 1'b0;
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            valid_reg <= 1'b0;
        end
        else
        begin
            busy_reg  <= busy_next;
            valid_reg <= valid_next;
        end
    end

    // Payload: request, position, running CRC and output byte
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            req_reg <= req_in;
            idx_reg <= '0;
            crc_reg <= hcfb_pkg::CRC8_INIT;
        end
        else if (step)
        begin
            idx_reg <= idx_reg + 4'd1;
            crc_reg <= hcfb_pkg::crc8_byte(crc_reg, cur.data);
        end
        if (step)
        begin
            data_reg <= cur.data;
            last_reg <= cur.last;
        end
    end

    assign stat.busy      = busy_reg;
    assign stat.take      = take;
    assign stat.step_last = step && cur.last;

    assign out_valid = valid_reg;
    assign out_data  = data_reg;
    assign out_last  = last_reg;

endmodule

// File: design/header_compression_feedback_builder.sv
// Top level of the header-compression feedback builder.
// Depends on hcfb_pkg, hcfb_req_buf, hcfb_emit and the assertion macro header.
//
//   channel   dir  tdata / tuser / tlast
//   s_*       in   request: tdata ack/opmode/SN/CID/add_crc, tuser mode
//   m_*       out  packet: tdata byte, tlast on the final byte
//   cfg_*     in   large_cid register write
//
// A request of N bytes (1 to 12) leaves the output one byte per cycle while
// m_tready holds, and a waiting next request's first byte follows the last
// byte of the previous one without a gap.
// A request passes the input register, then the sequencer, then the output register.
// Reset clears the valid flags, the sequencer and large_cid (small ids).
// A stalled output holds its byte; requests wait in the one-entry input register.
`include "header_compression_feedback_builder_defines.svh"

module header_compression_feedback_builder (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         s_tvalid,
    output logic                         s_tready,
    // [1:0] ack_type, [3:2] operating_mode, [35:4] sequence_number,
    // [49:36] context_id, [50] add_crc, [55:51] zero
    input  logic [hcfb_pkg::TDATA_W-1:0] s_tdata,
    // [0] mode
    input  logic                         s_tuser,
    output logic                         m_tvalid,
    input  logic                         m_tready,
    // [7:0] packet_byte
    output logic [7:0]                   m_tdata,
    // last_byte
    output logic                         m_tlast,
    input  logic                         cfg_wr_en,
    input  logic                         cfg_wr_data
);

    logic                      large_cid_reg;
    hcfb_pkg::hcfb_req_t       in_req;
    hcfb_pkg::hcfb_req_t       held_req;
    logic                      held_valid;
    hcfb_pkg::hcfb_emit_stat_t stat;

    // Configuration register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            large_cid_reg <= 1'b0;
        end
        else if (cfg_wr_en)
        begin
            large_cid_reg <= cfg_wr_data;
        end
    end

    // Unpack the request
    assign in_req.mode            = s_tuser;
    assign in_req.ack_type        = s_tdata[1:0];
    assign in_req.operating_mode  = s_tdata[3:2];
    assign in_req.sequence_number = s_tdata[35:4];
    assign in_req.context_id      = s_tdata[49:36];
    assign in_req.add_crc         = s_tdata[50];

    hcfb_req_buf u_req_buf (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .in_req     (in_req),
        .take       (stat.take),
        .held_valid (held_valid),
        .held_req   (held_req)
    );

    hcfb_emit u_emit (
        .clk       (clk),
        .rst_n     (rst_n),
        .large_cid (large_cid_reg),
        .req_valid (held_valid),
        .req_in    (held_req),
        .stat      (stat),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (m_tdata),
        .out_last  (m_tlast)
    );

    // A request enters the sequencer only from a full input register
    `HCFB_ASSERT_SAME(a_take_needs_req, clk, rst_n, stat.take, held_valid, "take without request")
    // A taken request makes the sequencer busy
    `HCFB_ASSERT_NEXT(a_take_busy, clk, rst_n, stat.take, stat.busy, "sequencer not busy")
    // The final byte of a packet shows up flagged on the output
    `HCFB_ASSERT_NEXT(a_last_out, clk, rst_n, stat.step_last, m_tvalid && m_tlast, "tlast lost")

endmodule

// File: bench/testbench.sv
`timescale 1ns / 1ps
// Testbench for header_compression_feedback_builder: sends feedback requests and checks
// every packet byte and its tlast flag against typed bytes or a local builder.
// Depends on hcfb_pkg and the builder RTL only.

module testbench;

    localparam int NO_TRANSFER_LIMIT = 2000;
    localparam int RANDOM_PHASES     = 4;
    localparam int ITEMS_PER_PHASE   = 110;

    typedef logic [7:0] octet_q_t [$];

    // One directed request; typed_count > 0 means the packet is written out here
    typedef struct packed {
        logic                  large_cid;
        hcfb_pkg::hcfb_req_t   req;
        logic [1:0]            typed_count;
        logic [0:2][7:0]       typed;
    } directed_row_t;

    // large_cid, {mode, ack, opmode, SN, CID, add_crc}, typed count, typed bytes
    localparam directed_row_t DIRECTED [20] = '{
        '{1'b0, '{1'b0, 2'd0, 2'd0, 32'h0000_0000, 14'h0000, 1'b0}, 2'd1, '{8'h00, 8'h00, 8'h00}},
        '{1'b0, '{1'b0, 2'd3, 2'd3, 32'hFFFF_FFFF, 14'h0000, 1'b1}, 2'd1, '{8'hFF, 8'h00, 8'h00}},
        '{1'b0, '{1'b0, 2'd0, 2'd0, 32'h1234_5678, 14'h0005, 1'b0}, 2'd2, '{8'hE5, 8'h78, 8'h00}},
        '{1'b0, '{1'b0, 2'd0, 2'd0, 32'h0000_00AB, 14'h3FF0, 1'b0}, 2'd2, '{8'hE0, 8'hAB, 8'h00}},
        '{1'b0, '{1'b1, 2'd0, 2'd0, 32'h0000_0000, 14'h0000, 1'b0}, 2'd2, '{8'h00, 8'h00, 8'h00}},
        '{1'b0, '{1'b1, 2'd3, 2'd3, 32'h0000_0FFF, 14'h0000, 1'b0}, 2'd2, '{8'hFF, 8'hFF, 8'h00}},
        '{1'b0, '{1'b1, 2'd1, 2'd2, 32'h0000_1000, 14'h0000, 1'b0}, 2'd0, '{8'h00, 8'h00, 8'h00}},
        '{1'b0, '{1'b1, 2'd2, 2'd1, 32'h000F_FFFF, 14'h0007, 1'b0}, 2'd0, '{8'h00, 8'h00, 8'h00}},
        '{1'b0, '{1'b1, 2'd0, 2'd3, 32'h0010_0000, 14'h0000, 1'b0}, 2'd0, '{8'h00, 8'h00, 8'h00}},
        '{1'b0, '{1'b1, 2'd3, 2'd0, 32'h0FFF_FFFF, 14'h0000, 1'b0}, 2'd0, '{8'h00, 8'h00, 8'h00}},
        '{1'b0, '{1'b1, 2'd1, 2'd1, 32'h1000_0000, 14'h0009, 1'b0}, 2'd0, '{8'h00, 8'h00, 8'h00}},
        '{1'b0, '{1'b1, 2'd2, 2'd2, 32'hFFFF_FFFF, 14'h000F, 1'b1}, 2'd0, '{8'h00, 8'h00, 8'h00}},
        '{1'b0, '{1'b1, 2'd0, 2'd0, 32'h0000_0000, 14'h0000, 1'b1}, 2'd0, '{8'h00, 8'h00, 8'h00}},
        '{1'b1, '{1'b0, 2'd0, 2'd0, 32'h0000_005A, 14'h0000, 1'b0}, 2'd2, '{8'h00, 8'h5A, 8'h00}},
        '{1'b1, '{1'b0, 2'd0, 2'd0, 32'h0000_0000, 14'h007F, 1'b0}, 2'd2, '{8'h7F, 8'h00, 8'h00}},
        '{1'b1, '{1'b0, 2'd0, 2'd0, 32'h0000_0001, 14'h0080, 1'b0}, 2'd3, '{8'h80, 8'h80, 8'h01}},
        '{1'b1, '{1'b0, 2'd0, 2'd0, 32'h0000_00FF, 14'h3FFF, 1'b0}, 2'd3, '{8'hBF, 8'hFF, 8'hFF}},
        '{1'b1, '{1'b1, 2'd2, 2'd1, 32'hFFFF_FFFF, 14'h3FFF, 1'b1}, 2'd0, '{8'h00, 8'h00, 8'h00}},
        '{1'b1, '{1'b1, 2'd0, 2'd0, 32'h0000_0800, 14'h0000, 1'b0}, 2'd0, '{8'h00, 8'h00, 8'h00}},
        '{1'b1, '{1'b1, 2'd3, 2'd2, 32'h0001_2345, 14'h00C8, 1'b1}, 2'd0, '{8'h00, 8'h00, 8'h00}}
    };

    logic                          clk;
    logic                          rst_n;
    logic                          s_tvalid;
    logic                          s_tready;
    logic [hcfb_pkg::TDATA_W-1:0]  s_tdata;
    logic                          s_tuser;
    logic                          m_tvalid;
    logic                          m_tready;
    logic [7:0]                    m_tdata;
    logic                          m_tlast;
    logic                          cfg_wr_en;
    logic                          cfg_wr_data;

    logic                          large_cid_shadow;
    logic                          steady;
    octet_q_t                      typed_on_bus;
    hcfb_pkg::hcfb_byte_t          pending_bytes [$];
    hcfb_pkg::hcfb_req_t           seen_req;
    octet_q_t                      seen_pkt;
    hcfb_pkg::hcfb_byte_t          want;
    int                            error_count;
    int                            quiet_cycles;

    header_compression_feedback_builder dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tlast     (m_tlast),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    // Build the feedback packet bytes for one request
    function automatic octet_q_t build_feedback(input hcfb_pkg::hcfb_req_t r,
                                                input logic large_ids);
        octet_q_t   pkt;
        int         opts;
        int         shift;
        logic [3:0] nibble;
        logic [7:0] crc;
        pkt = {};
        // context-id prefix
        if (large_ids)
        begin
            if (r.context_id <= 14'd127)
            begin
                pkt.push_back({1'b0, r.context_id[6:0]});
            end
            else
            begin
                pkt.push_back({hcfb_pkg::LARGE_CID_HDR, r.context_id[13:8]});
                pkt.push_back(r.context_id[7:0]);
            end
        end
        else if (r.context_id != 14'd0)
        begin
            pkt.push_back({hcfb_pkg::SMALL_CID_HDR, r.context_id[3:0]});
        end
        if (!r.mode)
        begin
            pkt.push_back(r.sequence_number[7:0]);
        end
        else
        begin
            // pick how many SN options the sequence number needs
            if (r.sequence_number < 32'h0000_1000)
            begin
                opts   = 0;
                nibble = r.sequence_number[11:8];
            end
            else if (r.sequence_number < 32'h0010_0000)
            begin
                opts   = 1;
                nibble = r.sequence_number[19:16];
            end
            else if (r.sequence_number < 32'h1000_0000)
            begin
                opts   = 2;
                nibble = r.sequence_number[27:24];
            end
            else
            begin
                opts   = 3;
                nibble = 4'h0;
            end
            shift = 8 * opts;
            pkt.push_back({r.ack_type, r.operating_mode, nibble});
            pkt.push_back(8'(r.sequence_number >> shift));
            repeat (opts)
            begin
                shift -= 8;
                pkt.push_back(hcfb_pkg::SN_OPT_HDR);
                pkt.push_back(8'(r.sequence_number >> shift));
            end
            // CRC option: checksum over the packet with its data byte still zero
            if (r.add_crc)
            begin
                pkt.push_back(hcfb_pkg::CRC_OPT_HDR);
                pkt.push_back(8'h00);
                crc = hcfb_pkg::CRC8_INIT;
                foreach (pkt[i])
                begin
                    crc ^= pkt[i];
                    repeat (8)
                    begin
                        crc = crc[0] ? ((crc >> 1) ^ hcfb_pkg::CRC8_POLY_REFL) : (crc >> 1);
                    end
                end
                pkt[pkt.size() - 1] = crc;
            end
        end
        return pkt;
    endfunction

    // Draw a request spread over all SN ranges and all kinds of context id
    function automatic hcfb_pkg::hcfb_req_t random_req();
        hcfb_pkg::hcfb_req_t r;
        r.mode           = 1'($urandom_range(0, 1));
        r.ack_type       = 2'($urandom_range(0, 3));
        r.operating_mode = 2'($urandom_range(0, 3));
        r.add_crc        = 1'($urandom_range(0, 1));
        case ($urandom_range(0, 4))
            0: r.sequence_number = $urandom_range(0, 32'h0000_0FFF);
            1: r.sequence_number = $urandom_range(32'h0000_1000, 32'h000F_FFFF);
            2: r.sequence_number = $urandom_range(32'h0010_0000, 32'h0FFF_FFFF);
            3: r.sequence_number = $urandom();
            default:
            begin
                case ($urandom_range(0, 7))
                    0: r.sequence_number = 32'h0000_0000;
                    1: r.sequence_number = 32'h0000_0FFF;
                    2: r.sequence_number = 32'h0000_1000;
                    3: r.sequence_number = 32'h000F_FFFF;
                    4: r.sequence_number = 32'h0010_0000;
                    5: r.sequence_number = 32'h0FFF_FFFF;
                    6: r.sequence_number = 32'h1000_0000;
                    default: r.sequence_number = 32'hFFFF_FFFF;
                endcase
            end
        endcase
        case ($urandom_range(0, 4))
            0: r.context_id = 14'd0;
            1: r.context_id = 14'($urandom_range(1, 15));
            2: r.context_id = 14'($urandom_range(16, 127));
            3: r.context_id = 14'($urandom_range(128, 16383));
            default: r.context_id = 14'($urandom_range(0, 16383));
        endcase
        return r;
    endfunction

    // Offer one request, with random gaps ahead of it, and hold it until the transfer
    task automatic send_req(input hcfb_pkg::hcfb_req_t r, input octet_q_t typed);
        @(negedge clk);
        while (!steady && $urandom_range(0, 99) < 33)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        typed_on_bus = typed;
        s_tvalid <= 1'b1;
        s_tuser  <= r.mode;
        s_tdata  <= {5'b0, r.add_crc, r.context_id, r.sequence_number,
                     r.operating_mode, r.ack_type};
        do
        begin
            @(posedge clk);
        end
        while (!s_tready);
    endtask

    // Drop the request stream and wait until every packet byte has come out
    task automatic drain();
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (pending_bytes.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (4) @(posedge clk);
    endtask

    // Write large_cid while the block is idle
    task automatic set_large_cid(input logic value);
        drain();
        @(negedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(negedge clk);
        cfg_wr_en   <= 1'b0;
        large_cid_shadow = value;
    endtask

    // Free-running clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Receiver: accept bytes with random stalls except in the steady stretch
    always @(negedge clk)
    begin
        m_tready <= steady || ($urandom_range(0, 99) >= 33);
    end

    // On each request transfer, queue the packet it must produce
    always @(posedge clk)
    begin
        if (rst_n && s_tvalid && s_tready)
        begin
            seen_req.mode            = s_tuser;
            seen_req.ack_type        = s_tdata[1:0];
            seen_req.operating_mode  = s_tdata[3:2];
            seen_req.sequence_number = s_tdata[35:4];
            seen_req.context_id      = s_tdata[49:36];
            seen_req.add_crc         = s_tdata[50];
            seen_pkt = (typed_on_bus.size() != 0) ? typed_on_bus
                                                  : build_feedback(seen_req, large_cid_shadow);
            foreach (seen_pkt[i])
            begin
                pending_bytes.push_back('{seen_pkt[i], i == seen_pkt.size() - 1});
            end
        end
    end

    // On each byte transfer, compare with the oldest pending byte
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pending_bytes.size() == 0)
            begin
                $error("packet_byte: no byte pending, got %02h (last %0b)", m_tdata, m_tlast);
                error_count++;
            end
            else
            begin
                want = pending_bytes.pop_front();
                if (m_tdata !== want.data)
                begin
                    $error("packet_byte: expected %02h, got %02h", want.data, m_tdata);
                    error_count++;
                end
                if (m_tlast !== want.last)
                begin
                    $error("last_byte: expected %0b, got %0b", want.last, m_tlast);
                    error_count++;
                end
            end
        end
    end

    // Watchdog: end the run after too long without any transfer
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            begin
                quiet_cycles = 0;
            end
            else
            begin
                quiet_cycles++;
            end
            if (quiet_cycles >= NO_TRANSFER_LIMIT)
            begin
                $display("FAIL");
                $finish;
            end
        end
    end

    // Reset, directed table, random phases, final verdict
    initial
    begin
        octet_q_t typed;
        octet_q_t no_typed;
        no_typed         = {};
        typed_on_bus     = {};
        error_count      = 0;
        quiet_cycles     = 0;
        steady           = 1'b0;
        large_cid_shadow = 1'b0;
        rst_n            = 1'b0;
        s_tvalid         = 1'b0;
        s_tdata          = '0;
        s_tuser          = 1'b0;
        m_tready         = 1'b0;
        cfg_wr_en        = 1'b0;
        cfg_wr_data      = 1'b0;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // walk the directed table, switching id size between its sections
        foreach (DIRECTED[i])
        begin
            if (i == 0 || DIRECTED[i].large_cid != large_cid_shadow)
            begin
                set_large_cid(DIRECTED[i].large_cid);
            end
            typed = {};
            for (int k = 0; k < DIRECTED[i].typed_count; k++)
            begin
                typed.push_back(DIRECTED[i].typed[k]);
            end
            send_req(DIRECTED[i].req, typed);
        end

        // random phases alternate id size; one runs without any stalls
        for (int phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            set_large_cid(1'(phase % 2));
            steady = (phase == 2);
            repeat (ITEMS_PER_PHASE) send_req(random_req(), no_typed);
        end

        drain();
        repeat (20) @(posedge clk);
        if (error_count == 0)
        begin
            $display("PASS");
        end
        else
        begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

// File: header_compression_feedback_builder.f
+incdir+design
design/hcfb_pkg.sv
design/hcfb_req_buf.sv
design/hcfb_layout.sv
design/hcfb_emit.sv
design/header_compression_feedback_builder.sv
bench/testbench.sv
